// File: hw/rtl/mstp_pkg.sv
// Shared types, constants and CRC functions for the MS/TP frame encoder.
package mstp_pkg;

    localparam logic [7:0]  PREAMBLE_A = 8'h55;
    localparam logic [7:0]  PREAMBLE_B = 8'hFF;
    localparam logic [7:0]  PREFIX_A   = 8'h01;
    localparam logic [7:0]  PREFIX_B   = 8'h04;
    localparam logic [7:0]  CRC8_INIT  = 8'hFF;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;

    // Byte positions within a frame as the back end walks them.
    localparam logic [3:0] POS_PRE_A   = 4'd0;
    localparam logic [3:0] POS_PRE_B   = 4'd1;
    localparam logic [3:0] POS_TYPE    = 4'd2;
    localparam logic [3:0] POS_DEST    = 4'd3;
    localparam logic [3:0] POS_SRC     = 4'd4;
    localparam logic [3:0] POS_LEN_HI  = 4'd5;
    localparam logic [3:0] POS_LEN_LO  = 4'd6;
    localparam logic [3:0] POS_HDR_CRC = 4'd7;
    localparam logic [3:0] POS_PFX_A   = 4'd8;
    localparam logic [3:0] POS_PFX_B   = 4'd9;
    localparam logic [3:0] POS_DATA    = 4'd10;
    localparam logic [3:0] POS_CRC_LO  = 4'd11;
    localparam logic [3:0] POS_CRC_HI  = 4'd12;

    // One classified item handed from the front end to the back end.
    typedef struct packed {
        logic        start;
        logic [7:0]  frame_type;
        logic [7:0]  dest_addr;
        logic [7:0]  source_addr;
        logic [7:0]  len_hi;
        logic [7:0]  len_lo;
        logic [7:0]  hdr_crc;
        logic [7:0]  data_byte;
        logic        fin;
        logic [15:0] data_crc;
    } mstp_cmd_t;

    // Bit 0 of the result is bit 8 of the shifted XOR sum, taken from bits 1 to 7 of crc ^ octet.
    function automatic logic [7:0] hdr_crc_step(input logic [7:0] octet,
                                                input logic [7:0] crc);
        logic [15:0] c;
        logic [15:0] m;
        c = {8'h00, crc ^ octet};
        m = c ^ (c << 1) ^ (c << 2) ^ (c << 3) ^ (c << 4) ^ (c << 5) ^ (c << 6)
          ^ (c << 7);
        return {m[7:1], m[8]};
    endfunction

    function automatic logic [15:0] data_crc_step(input logic [7:0] octet,
                                                  input logic [15:0] crc);
        logic [15:0] lo;
        logic [15:0] lon;
        lo  = {8'h00, crc[7:0] ^ octet};
        lon = {12'h000, lo[3:0]};
        return (crc >> 8) ^ (lo << 8) ^ (lo << 3) ^ (lo << 12) ^ (lo >> 4)
             ^ lon ^ (lon << 7);
    endfunction

    // Data CRC after the fixed prefix, known at elaboration.
    localparam logic [15:0] PREFIX_CRC =
        data_crc_step(PREFIX_B, data_crc_step(PREFIX_A, CRC16_INIT));

endpackage

// File: hw/rtl/mstp_front.sv
// Front end: accepts items, tracks the open frame and builds queue entries.
module mstp_front
    import mstp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 501
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       start_req,
    input  logic [7:0] frame_type,
    input  logic [7:0] dest_addr,
    input  logic [7:0] source_addr,
    input  logic [11:0] payload_len,
    input  logic [7:0] data_byte,
    output logic       push,
    output mstp_cmd_t  cmd
);

    localparam logic [11:0] MaxLen = 12'(MAX_PAYLOAD);

    logic        active_reg, active_next;
    logic [11:0] bytes_left_reg, bytes_left_next;
    logic [15:0] data_crc_reg, data_crc_next;

    logic [11:0] len_c;
    logic [15:0] flen;
    logic [7:0]  hc;
    logic [15:0] crc_base;
    logic [15:0] crc_new;
    logic [11:0] left_new;
    logic        fin;

    always_comb
    begin
        len_c    = (payload_len > MaxLen) ? MaxLen : payload_len;
        flen     = {4'h0, len_c} + 16'd2;
        hc       = hdr_crc_step(frame_type, CRC8_INIT);
        hc       = hdr_crc_step(dest_addr, hc);
        hc       = hdr_crc_step(source_addr, hc);
        hc       = hdr_crc_step(flen[15:8], hc);
        hc       = hdr_crc_step(flen[7:0], hc);
        crc_base = start_req ? PREFIX_CRC : data_crc_reg;
        crc_new  = data_crc_step(data_byte, crc_base);
        left_new = (start_req ? len_c : bytes_left_reg) - 12'd1;
        fin      = (left_new == 12'd0);

        cmd.start       = start_req;
        cmd.frame_type  = frame_type;
        cmd.dest_addr   = dest_addr;
        cmd.source_addr = source_addr;
        cmd.len_hi      = flen[15:8];
        cmd.len_lo      = flen[7:0];
        cmd.hdr_crc     = ~hc;
        cmd.data_byte   = data_byte;
        cmd.fin         = fin;
        cmd.data_crc    = ~crc_new;

        // A zero-length start and a byte outside a frame give no output.
        push = accept && (start_req ? (payload_len != 12'd0) : active_reg);

        active_next     = active_reg;
        bytes_left_next = bytes_left_reg;
        data_crc_next   = data_crc_reg;
        if (accept && start_req && payload_len == 12'd0)
        begin
            active_next     = 1'b0;
            bytes_left_next = 12'd0;
        end
        else if (push)
        begin
            active_next     = !fin;
            bytes_left_next = left_new;
            data_crc_next   = fin ? CRC16_INIT : crc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            bytes_left_reg <= 12'd0;
            data_crc_reg   <= CRC16_INIT;
        end
        else
        begin
            active_reg     <= active_next;
            bytes_left_reg <= bytes_left_next;
            data_crc_reg   <= data_crc_next;
        end
    end

endmodule

// File: hw/rtl/mstp_queue.sv
// Short queue of classified items between the front and back ends.
module mstp_queue
    import mstp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  mstp_cmd_t push_cmd,
    output logic      not_full,
    input  logic      pop,
    output logic      head_valid,
    output mstp_cmd_t head_cmd
);

    localparam int Depth = 4;

    mstp_cmd_t   entry_reg [Depth];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        do_push, do_pop;

    always_comb
    begin
        not_full   = (count_reg != 3'(Depth));
        head_valid = (count_reg != 3'd0);
        head_cmd   = entry_reg[rd_ptr_reg];
        do_push    = push && not_full;
        do_pop     = pop && head_valid;
        wr_ptr_next = do_push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b00, do_push} - {2'b00, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/mstp_back.sv
// Back end: walks each queued item byte by byte into the output register.
module mstp_back
    import mstp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  mstp_cmd_t head_cmd,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [7:0] out_byte,
    output logic      out_last,
    output logic      out_end
);

    logic [3:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       end_reg, end_next;

    logic [3:0] pos;
    logic [3:0] last_pos;
    logic [7:0] sel;
    logic       load;

    always_comb
    begin
        pos      = head_cmd.start ? step_reg : step_reg + POS_DATA;
        last_pos = head_cmd.fin ? POS_CRC_HI : POS_DATA;
        unique case (pos)
            POS_PRE_A:   sel = PREAMBLE_A;
            POS_PRE_B:   sel = PREAMBLE_B;
            POS_TYPE:    sel = head_cmd.frame_type;
            POS_DEST:    sel = head_cmd.dest_addr;
            POS_SRC:     sel = head_cmd.source_addr;
            POS_LEN_HI:  sel = head_cmd.len_hi;
            POS_LEN_LO:  sel = head_cmd.len_lo;
            POS_HDR_CRC: sel = head_cmd.hdr_crc;
            POS_PFX_A:   sel = PREFIX_A;
            POS_PFX_B:   sel = PREFIX_B;
            POS_DATA:    sel = head_cmd.data_byte;
            POS_CRC_LO:  sel = head_cmd.data_crc[7:0];
            POS_CRC_HI:  sel = head_cmd.data_crc[15:8];
            default:     sel = 8'h00;
        endcase

        load = head_valid && (!valid_reg || out_ready);
        pop  = load && (pos == last_pos);

        step_next = step_reg;
        if (load)
        begin
            step_next = pop ? 4'd0 : step_reg + 4'd1;
        end

        valid_next = load ? 1'b1 : (valid_reg && !out_ready);
        byte_next  = load ? sel : byte_reg;
        last_next  = load ? (pos == last_pos) : last_reg;
        end_next   = load ? (pos == POS_CRC_HI) : end_reg;

        out_valid = valid_reg;
        out_byte  = byte_reg;
        out_last  = last_reg;
        out_end   = end_reg;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: hw/rtl/mstp_frame_encoder_core.sv
// Top level of the MS/TP frame encoder: front end, item queue and back end.
//
// Each input item carries one payload byte; an item flagged as a frame start
// also carries the frame type, the addresses and the payload length, which
// is clamped to MAX_PAYLOAD. A start item produces the preamble, the header
// with its complemented CRC-8, the 0x01 0x04 prefix and its payload byte;
// the item carrying the last counted byte also produces the complemented
// data CRC-16, low byte first. A start with zero length drops any open frame
// and produces nothing, as does a byte arriving outside a frame. The front
// end takes one item per cycle while its four-entry queue has room, and the
// back end sends one frame byte per cycle while the output is ready, through
// a single output register, so a plain payload item yields one byte and a
// start item 11 bytes (13 for a one-byte payload). Long-run throughput is
// set by the output port at one byte per cycle; the queue absorbs the header
// bursts, and the input stalls only once it has filled. An accepted item is
// queued and then registered before it reaches the output. tlast marks the
// final byte caused by an input item, and tuser the last byte of a frame.
module mstp_frame_encoder_core
    import mstp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 501
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // frame_type [7:0], dest_addr [15:8], source_addr [23:16],
    // payload_len [35:24], data_byte [43:36], zero fill [47:44]
    input  logic [47:0] s_axis_tdata,
    // start_req [0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // frame_byte [7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // frame_end [0]
    output logic        m_axis_tuser
);

    logic      in_accept;
    logic      push;
    logic      not_full;
    logic      pop;
    logic      head_valid;
    mstp_cmd_t push_cmd;
    mstp_cmd_t head_cmd;

    assign s_axis_tready = not_full;
    assign in_accept     = s_axis_tvalid && not_full;

    mstp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .start_req   (s_axis_tuser),
        .frame_type  (s_axis_tdata[7:0]),
        .dest_addr   (s_axis_tdata[15:8]),
        .source_addr (s_axis_tdata[23:16]),
        .payload_len (s_axis_tdata[35:24]),
        .data_byte   (s_axis_tdata[43:36]),
        .push        (push),
        .cmd         (push_cmd)
    );

    mstp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .not_full   (not_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    mstp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_end    (m_axis_tuser)
    );

endmodule
